// ----- src/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/tmap_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tone map package
// Curve coefficients and internal widths shared by the tone map modules.
// ----------------------------------------------------------------------------
package tmap_pkg;

  // Curve input, unsigned Q5.12, saturated at 16.0.
  localparam int XW       = 17;
  localparam int X_FRAC   = 12;
  // Product of sample (10 fraction bits) and exposure (8 fraction bits).
  localparam int P_FRAC   = 18;
  // Width of A*x + B and C*x + D terms.
  localparam int AXW      = 30;
  // Width of numerator and denominator, 36 fraction bits.
  localparam int NUMW     = 46;
  localparam int EXP_W    = 16;
  localparam logic [EXP_W-1:0] EXPOSURE_RESET = 16'd2560;

  // Coefficients rounded to 12 fraction bits.
  localparam logic [13:0] COEF_A = 14'd10281;
  localparam logic [13:0] COEF_B = 14'd123;
  localparam logic [13:0] COEF_C = 14'd9953;
  localparam logic [13:0] COEF_D = 14'd2417;
  localparam logic [13:0] COEF_E = 14'd573;

endpackage

// ----- src/tmap_ifs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tone map stream interfaces
// Pixel input and output channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface tmap_in_if #(parameter int SW = 16);
  logic          valid;
  logic          ready;
  logic [SW-1:0] red_in;
  logic [SW-1:0] green_in;
  logic [SW-1:0] blue_in;

  modport source (output valid, red_in, green_in, blue_in, input ready);
  modport sink   (input valid, red_in, green_in, blue_in, output ready);
endinterface

interface tmap_out_if #(parameter int OW = 13);
  logic          valid;
  logic          ready;
  logic [OW-1:0] red_out;
  logic [OW-1:0] green_out;
  logic [OW-1:0] blue_out;

  modport source (output valid, red_out, green_out, blue_out, input ready);
  modport sink   (input valid, red_out, green_out, blue_out, output ready);
endinterface

// ----- src/tmap_curve.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tone map curve front end
// Exposure gain, saturation and the numerator and denominator polynomials
// of the rational curve, over four register stages.
// ----------------------------------------------------------------------------
module tmap_curve
  import tmap_pkg::*;
#(
  parameter int SW = 16,
  parameter int F  = 12,
  parameter int NW = NUMW + F + 2,
  parameter int DW = NUMW + 1
) (
  input  logic             clk,
  input  logic [3:0]       en,
  input  logic [SW-1:0]    sample,
  input  logic [EXP_W-1:0] exposure,
  output logic [NW-1:0]    dividend,
  output logic [DW-1:0]    divisor
);

  localparam int PW = SW + EXP_W;

  logic [PW-1:0]   prod;
  logic [XW-1:0]   x_next;
  logic [XW-1:0]   x;
  logic [AXW-1:0]  ax;
  logic [AXW-1:0]  cx;
  logic [NUMW-1:0] num;
  logic [NUMW-1:0] den;
  logic            sat;
  logic [P_FRAC+4:0] rnd;

  // Stage 1: exact exposure product.
  always_ff @(posedge clk) begin
    if (en[0]) prod <= PW'(sample) * PW'(exposure);
  end

  // Saturate at 16.0, otherwise round half up to 12 fraction bits.
  always_comb begin
    sat    = |prod[PW-1:P_FRAC+4];
    rnd    = {1'b0, prod[P_FRAC+3:0]} + (23'd1 << (P_FRAC - X_FRAC - 1));
    x_next = sat ? (XW'(1) << (X_FRAC + 4)) : rnd[P_FRAC+4:P_FRAC-X_FRAC];
  end

  // Stage 2: curve input and the inner linear terms.
  always_ff @(posedge clk) begin
    if (en[1]) begin
      x  <= x_next;
      ax <= AXW'(x_next) * AXW'(COEF_A) + (AXW'(COEF_B) << X_FRAC);
      cx <= AXW'(x_next) * AXW'(COEF_C) + (AXW'(COEF_D) << X_FRAC);
    end
  end

  // Stage 3: numerator and denominator.
  always_ff @(posedge clk) begin
    if (en[2]) begin
      num <= NUMW'(x) * NUMW'(ax);
      den <= NUMW'(x) * NUMW'(cx) + (NUMW'(COEF_E) << (2 * X_FRAC));
    end
  end

  // Stage 4: dividend and divisor for the rounded ratio.
  always_ff @(posedge clk) begin
    if (en[3]) begin
      dividend <= (NW'(num) << (F + 1)) + NW'(den);
      divisor  <= DW'(den) << 1;
    end
  end

endmodule

// ----- src/tmap_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tone map pipelined divider
// Restoring division, one quotient bit per register stage, followed by a
// stage that limits the result to 1.0.
// ----------------------------------------------------------------------------
module tmap_div
  import tmap_pkg::*;
#(
  parameter int F  = 12,
  parameter int NW = NUMW + F + 2,
  parameter int DW = NUMW + 1
) (
  input  logic          clk,
  input  logic [F+2:0]  en,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic [F:0]    result
);

  localparam int QW = F + 2;
  localparam int OW = F + 1;

  logic [NW-1:0] rem_s [QW];
  logic [DW-1:0] dv_s  [QW];
  logic [QW-1:0] quo_s [QW];

  // One stage per quotient bit, most significant first.
  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [NW-1:0] rem_in;
    logic [DW-1:0] dv_in;
    logic [QW-1:0] quo_in;
    logic [NW-1:0] shifted;
    logic          take;

    if (k == 0) begin : g_first
      assign rem_in = dividend;
      assign dv_in  = divisor;
      assign quo_in = '0;
    end else begin : g_rest
      assign rem_in = rem_s[k-1];
      assign dv_in  = dv_s[k-1];
      assign quo_in = quo_s[k-1];
    end

    assign shifted = NW'(dv_in) << (QW - 1 - k);
    assign take    = (rem_in >= shifted);

    always_ff @(posedge clk) begin
      if (en[k]) begin
        rem_s[k] <= take ? (rem_in - shifted) : rem_in;
        dv_s[k]  <= dv_in;
        quo_s[k] <= quo_in | (QW'(take) << (QW - 1 - k));
      end
    end
  end

  // Final stage: limit to 1.0.
  always_ff @(posedge clk) begin
    if (en[QW]) begin
      result <= (quo_s[QW-1] > (QW'(1) << F)) ? (OW'(1) << F) : quo_s[QW-1][OW-1:0];
    end
  end

endmodule

// ----- src/aces_filmic_tone_map.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ACES filmic tone map
// Three-channel tone mapper built as one deep pipeline per channel.
// ----------------------------------------------------------------------------
// Usage:
// Pixels enter on pix_in (valid/ready) as unsigned Q6.10 red, green and blue
// and leave on pix_out as unsigned Q1.OUT_FRAC_BITS, limited to 1.0. A beat
// is moved at each rising edge with valid and ready both high. The exposure
// gain (unsigned Q8.8) is written through exposure_we and exposure_wdata;
// the user must write it only while the block is idle, which the block does
// not enforce; reset sets it to 10.0. The pipeline has four stages for gain
// and polynomials, one per quotient bit of the divider, one for the limit.
// Throughput is one pixel per clock while pix_out.ready stays high, set by
// the one-bit-per-stage divider pipeline. Each stage has its own valid bit
// and advances when it is empty or the next stage advances, so bubbles are
// squeezed out and the block keeps taking beats while a result waits. When
// the receiver stalls the output holds and the pipeline fills, then
// pix_in.ready falls. Reset (synchronous, active high) empties the pipeline.
// ----------------------------------------------------------------------------
module aces_filmic_tone_map
  import tmap_pkg::*;
#(
  parameter int SAMPLE_WIDTH  = 16,
  parameter int OUT_FRAC_BITS = 12
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             exposure_we,
  input  logic [EXP_W-1:0] exposure_wdata,
  tmap_in_if.sink          pix_in,
  tmap_out_if.source       pix_out
);

  localparam int F  = OUT_FRAC_BITS;
  localparam int NW = NUMW + F + 2;
  localparam int DW = NUMW + 1;
  localparam int NS = F + 7;

  logic [EXP_W-1:0] exposure;
  logic [NS-1:0]    vld;
  logic [NS-1:0]    en;
  logic [NW-1:0]    dvd [3];
  logic [DW-1:0]    dvs [3];
  logic [F:0]       res [3];
  logic [SAMPLE_WIDTH-1:0] smp [3];

  // Exposure register.
  always_ff @(posedge clk) begin
    if (rst) begin
      exposure <= EXPOSURE_RESET;
    end else if (exposure_we) begin
      exposure <= exposure_wdata;
    end
  end

  // A stage advances when it is empty or its successor advances.
  always_comb begin
    en[NS-1] = !vld[NS-1] || pix_out.ready;
    for (int i = NS - 2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int i = 0; i < NS; i++) begin
        if (en[i]) vld[i] <= (i == 0) ? pix_in.valid : vld[(i == 0) ? 0 : i - 1];
      end
    end
  end

  assign smp[0] = pix_in.red_in;
  assign smp[1] = pix_in.green_in;
  assign smp[2] = pix_in.blue_in;

  // One curve and divider pipeline per channel.
  for (genvar c = 0; c < 3; c++) begin : g_chan
    tmap_curve #(.SW(SAMPLE_WIDTH), .F(F), .NW(NW), .DW(DW)) u_curve (
      .clk      (clk),
      .en       (en[3:0]),
      .sample   (smp[c]),
      .exposure (exposure),
      .dividend (dvd[c]),
      .divisor  (dvs[c])
    );

    tmap_div #(.F(F), .NW(NW), .DW(DW)) u_div (
      .clk      (clk),
      .en       (en[NS-1:4]),
      .dividend (dvd[c]),
      .divisor  (dvs[c]),
      .result   (res[c])
    );
  end

  assign pix_in.ready      = en[0];
  assign pix_out.valid     = vld[NS-1];
  assign pix_out.red_out   = res[0];
  assign pix_out.green_out = res[1];
  assign pix_out.blue_out  = res[2];

endmodule

// ----- src/tmap_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tone map port checker
// Assertions on the top level's channels, attached by a bind statement.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tmap_checker #(
  parameter int OUT_FRAC_BITS = 12
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [OUT_FRAC_BITS:0] red_out,
  input logic [OUT_FRAC_BITS:0] green_out,
  input logic [OUT_FRAC_BITS:0] blue_out
);

  localparam logic [OUT_FRAC_BITS:0] ONE = (OUT_FRAC_BITS + 1)'(1) << OUT_FRAC_BITS;

  // A stalled output beat stays offered.
  `ASSERT_CLK(a_hold_valid, clk, rst, out_valid && !out_ready |=> out_valid, "output beat dropped")

  // A stalled output beat keeps its data.
  `ASSERT_CLK(a_hold_data, clk, rst, out_valid && !out_ready |=> $stable(red_out) && $stable(green_out) && $stable(blue_out), "stalled output changed")

  // Results never exceed 1.0.
  `ASSERT_CLK(a_range, clk, rst, out_valid |-> red_out <= ONE && green_out <= ONE && blue_out <= ONE, "result above one")

  // With the output stage empty the whole pipeline can move.
  `ASSERT_CLK(a_ready, clk, rst, !out_valid |-> in_ready, "input blocked with empty output")

endmodule

bind aces_filmic_tone_map tmap_checker #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_tmap_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (pix_in.ready),
  .out_valid (pix_out.valid),
  .out_ready (pix_out.ready),
  .red_out   (pix_out.red_out),
  .green_out (pix_out.green_out),
  .blue_out  (pix_out.blue_out)
);
